// File: sv/via_pkg.sv
// via_pkg: shared types, register codes and helper functions for the
// interface adapter. No dependencies.
package via_pkg;

  typedef enum logic [3:0] {
    RS_ORB   = 4'd0,
    RS_ORA   = 4'd1,
    RS_DDRB  = 4'd2,
    RS_DDRA  = 4'd3,
    RS_T1CL  = 4'd4,
    RS_T1CH  = 4'd5,
    RS_T1LL  = 4'd6,
    RS_T1LH  = 4'd7,
    RS_T2CL  = 4'd8,
    RS_T2CH  = 4'd9,
    RS_SR    = 4'd10,
    RS_ACR   = 4'd11,
    RS_PCR   = 4'd12,
    RS_IFR   = 4'd13,
    RS_IER   = 4'd14,
    RS_ORA_NH = 4'd15
  } via_reg_t;

  // bit positions in the control flag word
  localparam int F_PREV_CA1 = 0;
  localparam int F_PREV_CA2 = 1;
  localparam int F_PREV_CB1 = 2;
  localparam int F_PREV_CB2 = 3;
  localparam int F_LATCH_A  = 4;
  localparam int F_LATCH_B  = 5;
  localparam int F_OUT_CA2  = 6;
  localparam int F_OUT_CB1  = 7;
  localparam int F_OUT_CB2  = 8;
  localparam int F_T1_START = 9;
  localparam int F_T1_RUN   = 10;
  localparam int F_T2_START = 11;
  localparam int F_T2_RUN   = 12;
  localparam int F_T2_DONE  = 13;
  localparam int F_SR_START = 14;
  localparam int F_SR_RUN   = 15;

  localparam logic [15:0] FLAGS_RESET = 16'h0140;

  localparam logic [1:0] T1_ONESHOT_PB7 = 2'b10;
  localparam logic [1:0] T1_FREE_PB7    = 2'b11;
  localparam logic [2:0] SR_OFF         = 3'd0;
  localparam logic [2:0] SR_OUT_FREE    = 3'd4;
  localparam logic [1:0] SR_SUB_CLK     = 2'd2;
  localparam logic [1:0] SR_SUB_EXT     = 2'd3;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       irq_n;
    logic [7:0] port_a_out;
    logic [7:0] port_a_dir;
    logic [7:0] port_b_out;
    logic [7:0] port_b_dir;
    logic [2:0] ctrl_drive;
    logic [2:0] ctrl_level;
  } via_res_t;

  function automatic logic cb1_driven(input logic [2:0] m);
    return (m != 3'd0) && (m != 3'd3) && (m != 3'd7);
  endfunction

  function automatic logic line2_level(input logic [3:0] ctl, input logic cur,
                                       input logic access, input logic act1);
    logic v;
    v = cur;
    case (ctl[3:1])
      3'b100: begin
        if (access) v = 1'b0;
        if (act1) v = 1'b1;
      end
      3'b101:  v = ~access;
      default: v = ctl[1];
    endcase
    return v;
  endfunction

endpackage

// File: sv/via_core.sv
// via_core: adapter register state and the per-cycle update logic.
// Depends on via_pkg.
module via_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic               sel,
  input  logic               rd,
  input  logic [3:0]         addr,
  input  logic [7:0]         wdata,
  input  logic [7:0]         pa,
  input  logic [7:0]         pb,
  input  logic               ca1,
  input  logic               ca2,
  input  logic               cb1,
  input  logic               cb2,
  output via_pkg::via_res_t  res
);

  logic [7:0]  ora_r, orb_r, ddra_r, ddrb_r, ila_r, ilb_r, acr_r, pcr_r, ifr_r;
  logic [6:0]  ier_r;
  logic [15:0] t1l_r, t1c_r, t2l_r, t2c_r, f_r;
  logic [7:0]  sr_r, st_r;
  logic [3:0]  sc_r;
  logic        ppb6_r;

  logic [7:0]  ora_nxt, orb_nxt, ddra_nxt, ddrb_nxt, ila_nxt, ilb_nxt;
  logic [7:0]  acr_nxt, pcr_nxt, ifr_nxt, sr_nxt, st_nxt;
  logic [6:0]  ier_nxt;
  logic [15:0] t1l_nxt, t1c_nxt, t2l_nxt, t2c_nxt, f_nxt;
  logic [3:0]  sc_nxt;
  logic        ppb6_nxt;

  always_comb begin
    logic [3:0] pa_ctl, pb_ctl;
    logic ca1t, ca2t, cb1t, cb2t, cb1_rise, t1s, t2s, srs, pb6, run, go;
    logic [2:0] smode;
    logic ev_rd_a, ev_wr_a, ev_rd_b, ev_wr_b, ev_t1, ev_t2, ev_sr;
    logic [6:0] set, clr;
    logic [7:0] rdata;
    logic [2:0] drive, level;

    ora_nxt = ora_r; orb_nxt = orb_r; ddra_nxt = ddra_r; ddrb_nxt = ddrb_r;
    ila_nxt = ila_r; ilb_nxt = ilb_r; acr_nxt = acr_r; pcr_nxt = pcr_r;
    ifr_nxt = ifr_r; ier_nxt = ier_r; t1l_nxt = t1l_r; t1c_nxt = t1c_r;
    t2l_nxt = t2l_r; t2c_nxt = t2c_r; f_nxt = f_r; sr_nxt = sr_r;
    st_nxt = st_r; sc_nxt = sc_r; ppb6_nxt = ppb6_r;
    ev_rd_a = 1'b0; ev_wr_a = 1'b0; ev_rd_b = 1'b0; ev_wr_b = 1'b0;
    ev_t1 = 1'b0; ev_t2 = 1'b0; ev_sr = 1'b0;
    t1s = 1'b0; t2s = 1'b0; srs = 1'b0; go = 1'b0; run = 1'b0;
    rdata = 8'h00;

    pa_ctl = pcr_r[3:0];
    pb_ctl = pcr_r[7:4];
    if (!acr_r[0] || !f_r[via_pkg::F_LATCH_A]) ila_nxt = pa;
    if (!acr_r[1] || !f_r[via_pkg::F_LATCH_B]) ilb_nxt = pb;

    ca1t = pa_ctl[0] ? (ca1 && !f_r[via_pkg::F_PREV_CA1])
                     : (!ca1 && f_r[via_pkg::F_PREV_CA1]);
    ca2t = !pa_ctl[3] && (pa_ctl[2] ? (ca2 && !f_r[via_pkg::F_PREV_CA2])
                                    : (!ca2 && f_r[via_pkg::F_PREV_CA2]));
    cb1t = pb_ctl[0] ? (cb1 && !f_r[via_pkg::F_PREV_CB1])
                     : (!cb1 && f_r[via_pkg::F_PREV_CB1]);
    cb2t = !pb_ctl[3] && (pb_ctl[2] ? (cb2 && !f_r[via_pkg::F_PREV_CB2])
                                    : (!cb2 && f_r[via_pkg::F_PREV_CB2]));
    cb1_rise = cb1 && !f_r[via_pkg::F_PREV_CB1];
    if (ca1t) f_nxt[via_pkg::F_LATCH_A] = 1'b1;
    if (cb1t) f_nxt[via_pkg::F_LATCH_B] = 1'b1;
    f_nxt[via_pkg::F_PREV_CA1] = ca1;
    f_nxt[via_pkg::F_PREV_CA2] = ca2;
    f_nxt[via_pkg::F_PREV_CB1] = cb1;
    f_nxt[via_pkg::F_PREV_CB2] = cb2;

    // timer 1
    if (f_nxt[via_pkg::F_T1_START]) begin
      t1c_nxt = t1l_r;
      f_nxt[via_pkg::F_T1_START] = 1'b0;
      f_nxt[via_pkg::F_T1_RUN] = 1'b1;
      if (acr_r[7:6] == via_pkg::T1_ONESHOT_PB7) orb_nxt[7] = 1'b0;
    end else if (f_nxt[via_pkg::F_T1_RUN]) begin
      if (t1c_r == 16'd0) begin
        t1s = 1'b1;
        if (acr_r[7:6] == via_pkg::T1_FREE_PB7) orb_nxt[7] = ~orb_nxt[7];
        else if (acr_r[7:6] == via_pkg::T1_ONESHOT_PB7) orb_nxt[7] = 1'b1;
        f_nxt[via_pkg::F_T1_START] = acr_r[6];
        f_nxt[via_pkg::F_T1_RUN] = 1'b0;
      end
      t1c_nxt = t1c_r - 16'd1;
    end

    // timer 2, PB6 taken from the freshly updated latch
    pb6 = ilb_nxt[6];
    if (f_nxt[via_pkg::F_T2_START]) begin
      t2c_nxt = t2l_r;
      f_nxt[via_pkg::F_T2_START] = 1'b0;
      f_nxt[via_pkg::F_T2_RUN] = 1'b1;
      f_nxt[via_pkg::F_T2_DONE] = 1'b0;
      ppb6_nxt = pb6;
    end else if (f_nxt[via_pkg::F_T2_RUN]) begin
      if (t2c_r == 16'd0 && !f_nxt[via_pkg::F_T2_DONE]) begin
        t2s = 1'b1;
        f_nxt[via_pkg::F_T2_DONE] = 1'b1;
      end
      if (!acr_r[5] || (ppb6_r && !pb6)) t2c_nxt = t2c_r - 16'd1;
      ppb6_nxt = pb6;
    end

    // shift register
    smode = acr_r[4:2];
    if (f_nxt[via_pkg::F_SR_START]) begin
      f_nxt[via_pkg::F_SR_START] = 1'b0;
      f_nxt[via_pkg::F_SR_RUN] = 1'b1;
      sc_nxt = 4'd0;
      st_nxt = 8'd1;
      f_nxt[via_pkg::F_OUT_CB1] = 1'b1;
    end else if (smode != via_pkg::SR_OFF && f_nxt[via_pkg::F_SR_RUN]) begin
      run = 1'b1;
      if (sc_r >= 4'd8) begin
        if (smode != via_pkg::SR_OUT_FREE) begin
          f_nxt[via_pkg::F_SR_RUN] = 1'b0;
          srs = 1'b1;
          run = 1'b0;
        end else begin
          sc_nxt = 4'd0;
        end
      end
    end
    if (run) begin
      if (smode[1:0] == via_pkg::SR_SUB_CLK) begin
        f_nxt[via_pkg::F_OUT_CB1] = ~f_nxt[via_pkg::F_OUT_CB1];
        go = f_nxt[via_pkg::F_OUT_CB1];
      end else if (smode[1:0] == via_pkg::SR_SUB_EXT) begin
        go = cb1_rise;
      end else begin
        st_nxt = st_r - 8'd1;
        if (st_nxt == 8'd0) begin
          f_nxt[via_pkg::F_OUT_CB1] = ~f_nxt[via_pkg::F_OUT_CB1];
          go = f_nxt[via_pkg::F_OUT_CB1];
          st_nxt = t2l_r[7:0];
        end
      end
      if (go) begin
        if (smode[2]) begin
          f_nxt[via_pkg::F_OUT_CB2] = sr_r[7];
          sr_nxt = {sr_r[6:0], sr_r[7]};
        end else begin
          sr_nxt = {sr_r[6:0], cb2};
        end
        sc_nxt = sc_nxt + 4'd1;
      end
    end

    // bus access
    if (sel && !rd) begin
      case (via_pkg::via_reg_t'(addr))
        via_pkg::RS_ORB:  begin orb_nxt = wdata; ev_wr_b = 1'b1; end
        via_pkg::RS_ORA:  begin ora_nxt = wdata; ev_wr_a = 1'b1; end
        via_pkg::RS_DDRB: ddrb_nxt = wdata;
        via_pkg::RS_DDRA: ddra_nxt = wdata;
        via_pkg::RS_T1CL, via_pkg::RS_T1LL: t1l_nxt[7:0] = wdata;
        via_pkg::RS_T1CH: begin
          t1l_nxt[15:8] = wdata;
          ev_t1 = 1'b1;
          f_nxt[via_pkg::F_T1_START] = 1'b1;
        end
        via_pkg::RS_T1LH: begin t1l_nxt[15:8] = wdata; ev_t1 = 1'b1; end
        via_pkg::RS_T2CL: t2l_nxt[7:0] = wdata;
        via_pkg::RS_T2CH: begin
          t2l_nxt[15:8] = wdata;
          ev_t2 = 1'b1;
          f_nxt[via_pkg::F_T2_START] = 1'b1;
        end
        via_pkg::RS_SR: begin
          sr_nxt = wdata;
          ev_sr = 1'b1;
          f_nxt[via_pkg::F_SR_START] = 1'b1;
        end
        via_pkg::RS_ACR: begin
          acr_nxt = wdata;
          if (via_pkg::cb1_driven(wdata[4:2])) f_nxt[via_pkg::F_OUT_CB1] = 1'b1;
        end
        via_pkg::RS_PCR: pcr_nxt = wdata;
        via_pkg::RS_IFR: ifr_nxt = ifr_r & ~{1'b0, wdata[6:0]};
        via_pkg::RS_IER: begin
          if (wdata[7]) ier_nxt = ier_r | wdata[6:0];
          else ier_nxt = ier_r & ~wdata[6:0];
        end
        default: ora_nxt = wdata;
      endcase
    end else if (sel) begin
      case (via_pkg::via_reg_t'(addr))
        via_pkg::RS_ORB: begin
          ev_rd_b = 1'b1;
          rdata = (ilb_nxt & ~ddrb_r) | (orb_nxt & ddrb_r);
        end
        via_pkg::RS_ORA:  begin ev_rd_a = 1'b1; rdata = ila_nxt; end
        via_pkg::RS_DDRB: rdata = ddrb_r;
        via_pkg::RS_DDRA: rdata = ddra_r;
        via_pkg::RS_T1CL: begin ev_t1 = 1'b1; rdata = t1c_nxt[7:0]; end
        via_pkg::RS_T1CH: rdata = t1c_nxt[15:8];
        via_pkg::RS_T1LL: rdata = t1l_r[7:0];
        via_pkg::RS_T1LH: rdata = t1l_r[15:8];
        via_pkg::RS_T2CL: begin ev_t2 = 1'b1; rdata = t2c_nxt[7:0]; end
        via_pkg::RS_T2CH: rdata = t2c_nxt[15:8];
        via_pkg::RS_SR: begin
          ev_sr = 1'b1;
          f_nxt[via_pkg::F_SR_START] = 1'b1;
          rdata = sr_nxt;
        end
        via_pkg::RS_ACR: rdata = acr_r;
        via_pkg::RS_PCR: rdata = pcr_r;
        via_pkg::RS_IFR: rdata = ifr_r;
        via_pkg::RS_IER: rdata = {1'b1, ier_r};
        default:         rdata = pa;
      endcase
      if (ev_rd_a) f_nxt[via_pkg::F_LATCH_A] = 1'b0;
      if (ev_rd_b) f_nxt[via_pkg::F_LATCH_B] = 1'b0;
    end

    // CA2 / CB2 output modes follow the new PCR
    pa_ctl = pcr_nxt[3:0];
    pb_ctl = pcr_nxt[7:4];
    if (pa_ctl[3])
      f_nxt[via_pkg::F_OUT_CA2] = via_pkg::line2_level(pa_ctl,
          f_nxt[via_pkg::F_OUT_CA2], ev_rd_a | ev_wr_a, ca1t);
    if (pb_ctl[3] && !acr_nxt[4])
      f_nxt[via_pkg::F_OUT_CB2] = via_pkg::line2_level(pb_ctl,
          f_nxt[via_pkg::F_OUT_CB2], ev_wr_b, cb1t);

    set = {t1s, t2s, cb1t, cb2t, srs, ca1t, ca2t};
    clr = {ev_t1, ev_t2, {2{ev_rd_b | ev_wr_b}}, ev_sr, {2{ev_rd_a | ev_wr_a}}};
    // independent-interrupt modes keep CA2/CB2 flags on port access
    if (pcr_nxt[3] == 1'b0 && pcr_nxt[1] == 1'b1) clr[0] = 1'b0;
    if (pcr_nxt[7] == 1'b0 && pcr_nxt[5] == 1'b1) clr[3] = 1'b0;
    ifr_nxt[6:0] = (ifr_nxt[6:0] | set) & ~clr;
    ifr_nxt[7] = |(ifr_nxt[6:0] & ier_nxt);

    drive = 3'b000;
    level = 3'b000;
    if (pcr_nxt[3]) begin
      drive[0] = 1'b1;
      level[0] = f_nxt[via_pkg::F_OUT_CA2];
    end
    if (via_pkg::cb1_driven(acr_nxt[4:2])) begin
      drive[1] = 1'b1;
      level[1] = f_nxt[via_pkg::F_OUT_CB1];
    end
    if (pcr_nxt[7] || acr_nxt[4]) begin
      drive[2] = 1'b1;
      level[2] = f_nxt[via_pkg::F_OUT_CB2];
    end

    res.read_data  = rdata;
    res.read_valid = sel && rd;
    res.irq_n      = ~ifr_nxt[7];
    res.port_a_out = ora_nxt;
    res.port_a_dir = ddra_nxt;
    res.port_b_out = orb_nxt;
    res.port_b_dir = ddrb_nxt;
    res.ctrl_drive = drive;
    res.ctrl_level = level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ora_r <= '0; orb_r <= '0; ddra_r <= '0; ddrb_r <= '0;
      ila_r <= '0; ilb_r <= '0; acr_r <= '0; pcr_r <= '0;
      ifr_r <= '0; ier_r <= '0; t1l_r <= '0; t1c_r <= '0;
      t2l_r <= '0; t2c_r <= '0; sr_r <= '0; sc_r <= '0; st_r <= '0;
      f_r <= via_pkg::FLAGS_RESET;
      ppb6_r <= 1'b0;
    end else if (acc) begin
      ora_r <= ora_nxt; orb_r <= orb_nxt; ddra_r <= ddra_nxt; ddrb_r <= ddrb_nxt;
      ila_r <= ila_nxt; ilb_r <= ilb_nxt; acr_r <= acr_nxt; pcr_r <= pcr_nxt;
      ifr_r <= ifr_nxt; ier_r <= ier_nxt; t1l_r <= t1l_nxt; t1c_r <= t1c_nxt;
      t2l_r <= t2l_nxt; t2c_r <= t2c_nxt; sr_r <= sr_nxt; sc_r <= sc_nxt;
      st_r <= st_nxt; f_r <= f_nxt; ppb6_r <= ppb6_nxt;
    end
  end

endmodule

// File: sv/versatile_interface_adapter.sv
// Each request is one bus clock cycle of the adapter: register access,
// timers, shifter and interrupt logic all advance once per request. A request
// is taken every clock unless the output is stalled; its result appears in
// the output register in the next cycle, and a request is still taken while
// that result waits, as long as the result is taken in the same cycle.
// Throughput is one request per clock unless stalled, set by the single
// register state update in via_core. versatile_interface_adapter: handshake
// and result register around via_core. Depends on via_pkg and via_core.
module versatile_interface_adapter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_select,
  input  logic       in_func,
  input  logic [3:0] in_reg_addr,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_port_a_pins,
  input  logic [7:0] in_port_b_pins,
  input  logic       in_ca1_pin,
  input  logic       in_ca2_pin,
  input  logic       in_cb1_pin,
  input  logic       in_cb2_pin,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_read_valid,
  output logic       out_irq_n,
  output logic [7:0] out_port_a_out,
  output logic [7:0] out_port_a_dir,
  output logic [7:0] out_port_b_out,
  output logic [7:0] out_port_b_dir,
  output logic [2:0] out_ctrl_drive,
  output logic [2:0] out_ctrl_level
);

  logic               acc;
  logic               out_valid_r;
  via_pkg::via_res_t  res;
  via_pkg::via_res_t  res_r;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  via_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .sel   (in_select),
    .rd    (in_func),
    .addr  (in_reg_addr),
    .wdata (in_write_data),
    .pa    (in_port_a_pins),
    .pb    (in_port_b_pins),
    .ca1   (in_ca1_pin),
    .ca2   (in_ca2_pin),
    .cb1   (in_cb1_pin),
    .cb2   (in_cb2_pin),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = res_r.read_data;
  assign out_read_valid = res_r.read_valid;
  assign out_irq_n      = res_r.irq_n;
  assign out_port_a_out = res_r.port_a_out;
  assign out_port_a_dir = res_r.port_a_dir;
  assign out_port_b_out = res_r.port_b_out;
  assign out_port_b_dir = res_r.port_b_dir;
  assign out_ctrl_drive = res_r.ctrl_drive;
  assign out_ctrl_level = res_r.ctrl_level;

endmodule

// File: sv/via_checker.sv
// via_checker: port-level assertions for the adapter, bound to the top level.
// Depends on versatile_interface_adapter ports only.
module via_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_func,
  input logic       in_select,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data,
  input logic       out_read_valid,
  input logic [2:0] out_ctrl_drive,
  input logic [2:0] out_ctrl_level
);

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("input stalled with empty result slot");

  a_no_data_without_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_read_valid) |-> (out_read_data == 8'h00))
    else $error("read data driven on a cycle without a read");

  a_level_only_when_driven: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_ctrl_level & ~out_ctrl_drive) == 3'b000))
    else $error("control level set on an undriven line");

  a_read_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (out_valid && out_read_valid == $past(in_select && in_func)))
    else $error("read_valid does not match the accepted request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_read_data)))
    else $error("stalled result changed");

endmodule

bind versatile_interface_adapter via_checker u_via_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_func        (in_func),
  .in_select      (in_select),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_data  (out_read_data),
  .out_read_valid (out_read_valid),
  .out_ctrl_drive (out_ctrl_drive),
  .out_ctrl_level (out_ctrl_level)
);

// File: tb/versatile_interface_adapter_test.sv
// Self-checking bench for versatile_interface_adapter: a directed and a random
// stream of bus cycles checked against an in-bench cycle predictor.
// Depends on via_pkg and the adapter RTL.
module versatile_interface_adapter_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              sel;
    logic              rd;
    via_pkg::via_reg_t addr;
    logic [7:0]        wd;
    logic [7:0]        pa;
    logic [7:0]        pb;
    logic              ca1, ca2, cb1, cb2;
  } bus_cycle_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_select = 1'b0, in_func = 1'b0;
  logic [3:0] in_reg_addr = '0;
  logic [7:0] in_write_data = '0, in_port_a_pins = '0, in_port_b_pins = '0;
  logic in_ca1_pin = 1'b0, in_ca2_pin = 1'b0, in_cb1_pin = 1'b0, in_cb2_pin = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_read_data, out_port_a_out, out_port_a_dir, out_port_b_out, out_port_b_dir;
  logic out_read_valid, out_irq_n;
  logic [2:0] out_ctrl_drive, out_ctrl_level;

  versatile_interface_adapter uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [7:0] ora, orb, ddra, ddrb, lat_a, lat_b, acr, pcr, ifr;
  logic [6:0] ier;
  logic [15:0] t1_lat, t1_cnt, t2_lat, t2_cnt;
  logic [7:0] sreg, sr_tick;
  logic [3:0] sr_bits;
  logic prv_ca1, prv_ca2, prv_cb1, prv_cb2, hold_a, hold_b;
  logic lvl_ca2, lvl_cb1, lvl_cb2, t1_go, t1_run, t2_go, t2_run, t2_done;
  logic sr_go, sr_run, prv_pb6;

  bus_cycle_t         pending[$];
  bus_cycle_t         cur;
  via_pkg::via_res_t  expected_res[$];
  int                 failures = 0;
  int                 n_checked = 0, n_irq = 0, n_reads = 0;
  logic               taken = 1'b0;
  int                 in_gap = 0, out_gap = 0;
  bit                 idling = 1'b1;
  int unsigned        cycles = 0;

  function automatic logic edge_hit(logic now, logic was, logic pos);
    return pos ? (now && !was) : (!now && was);
  endfunction

  function automatic logic cb1_out_mode(logic [2:0] m);
    return m != 3'd0 && m != 3'd3 && m != 3'd7;
  endfunction

  function automatic logic ctl2_level(logic [3:0] ctl, logic cur_l, logic acc, logic act1);
    logic v;
    v = cur_l;
    if (ctl[3:1] == 3'b100) begin
      if (acc) v = 1'b0;
      if (act1) v = 1'b1;
    end else if (ctl[3:1] == 3'b101) begin
      v = !acc;
    end else begin
      v = ctl[1];
    end
    return v;
  endfunction

  task automatic adapter_reset();
    {ora, orb, ddra, ddrb, lat_a, lat_b, acr, pcr, ifr} = '0;
    ier = '0;
    {t1_lat, t1_cnt, t2_lat, t2_cnt} = '0;
    {sreg, sr_tick, sr_bits} = '0;
    {prv_ca1, prv_ca2, prv_cb1, prv_cb2, hold_a, hold_b} = '0;
    {lvl_cb1, t1_go, t1_run, t2_go, t2_run, t2_done, sr_go, sr_run, prv_pb6} = '0;
    lvl_ca2 = 1'b1;
    lvl_cb2 = 1'b1;
  endtask

  task automatic adapter_cycle(input bus_cycle_t c, output via_pkg::via_res_t r);
    logic [3:0] pa_ctl, pb_ctl;
    logic [2:0] sm;
    logic ca1t, ca2t, cb1t, cb2t, t1s, t2s, srs, rise, pb6, go;
    logic rd_a, wr_a, rd_b, wr_b, t1c, t2c, src;
    logic [7:0] clr, setf, rdata;
    pa_ctl = pcr[3:0];
    pb_ctl = pcr[7:4];
    {t1s, t2s, srs, go, rd_a, wr_a, rd_b, wr_b, t1c, t2c, src} = '0;
    rdata = '0;
    if (!acr[0] || !hold_a) lat_a = c.pa;
    if (!acr[1] || !hold_b) lat_b = c.pb;
    ca1t = edge_hit(c.ca1, prv_ca1, pa_ctl[0]);
    ca2t = !pa_ctl[3] && edge_hit(c.ca2, prv_ca2, pa_ctl[2]);
    cb1t = edge_hit(c.cb1, prv_cb1, pb_ctl[0]);
    cb2t = !pb_ctl[3] && edge_hit(c.cb2, prv_cb2, pb_ctl[2]);
    rise = c.cb1 && !prv_cb1;
    if (ca1t) hold_a = 1'b1;
    if (cb1t) hold_b = 1'b1;
    {prv_ca1, prv_ca2, prv_cb1, prv_cb2} = {c.ca1, c.ca2, c.cb1, c.cb2};

    // timer 1
    if (t1_go) begin
      t1_cnt = t1_lat;
      t1_go = 1'b0;
      t1_run = 1'b1;
      if (acr[7:6] == via_pkg::T1_ONESHOT_PB7) orb[7] = 1'b0;
    end else if (t1_run) begin
      if (t1_cnt == 16'd0) begin
        t1s = 1'b1;
        if (acr[7:6] == via_pkg::T1_FREE_PB7) orb[7] = !orb[7];
        else if (acr[7:6] == via_pkg::T1_ONESHOT_PB7) orb[7] = 1'b1;
        t1_go = acr[6];
        t1_run = 1'b0;
      end
      t1_cnt = t1_cnt - 16'd1;
    end

    // timer 2
    pb6 = lat_b[6];
    if (t2_go) begin
      t2_cnt = t2_lat;
      t2_go = 1'b0;
      t2_run = 1'b1;
      t2_done = 1'b0;
      prv_pb6 = pb6;
    end else if (t2_run) begin
      if (t2_cnt == 16'd0 && !t2_done) begin
        t2s = 1'b1;
        t2_done = 1'b1;
      end
      if (!acr[5] || (prv_pb6 && !pb6)) t2_cnt = t2_cnt - 16'd1;
      prv_pb6 = pb6;
    end

    // shifter
    sm = acr[4:2];
    if (sr_go) begin
      sr_go = 1'b0;
      sr_run = 1'b1;
      sr_bits = '0;
      sr_tick = 8'd1;
      lvl_cb1 = 1'b1;
    end else if (sm != via_pkg::SR_OFF && sr_run) begin
      if (sr_bits >= 4'd8 && sm != via_pkg::SR_OUT_FREE) begin
        sr_run = 1'b0;
        srs = 1'b1;
      end else begin
        if (sr_bits >= 4'd8) sr_bits = '0;
        if (sm[1:0] == via_pkg::SR_SUB_CLK) begin
          lvl_cb1 = !lvl_cb1;
          go = lvl_cb1;
        end else if (sm[1:0] == via_pkg::SR_SUB_EXT) begin
          go = rise;
        end else begin
          sr_tick = sr_tick - 8'd1;
          if (sr_tick == 8'd0) begin
            lvl_cb1 = !lvl_cb1;
            go = lvl_cb1;
            sr_tick = t2_lat[7:0];
          end
        end
        if (go) begin
          if (sm[2]) begin
            lvl_cb2 = sreg[7];
            sreg = {sreg[6:0], sreg[7]};
          end else begin
            sreg = {sreg[6:0], c.cb2};
          end
          sr_bits = sr_bits + 4'd1;
        end
      end
    end

    if (c.sel && !c.rd) begin
      case (c.addr)
        via_pkg::RS_ORB: begin orb = c.wd; wr_b = 1'b1; end
        via_pkg::RS_ORA, via_pkg::RS_ORA_NH: begin
          ora = c.wd;
          wr_a = (c.addr == via_pkg::RS_ORA);
        end
        via_pkg::RS_DDRB: ddrb = c.wd;
        via_pkg::RS_DDRA: ddra = c.wd;
        via_pkg::RS_T1CL, via_pkg::RS_T1LL: t1_lat[7:0] = c.wd;
        via_pkg::RS_T1CH: begin t1_lat[15:8] = c.wd; t1c = 1'b1; t1_go = 1'b1; end
        via_pkg::RS_T1LH: begin t1_lat[15:8] = c.wd; t1c = 1'b1; end
        via_pkg::RS_T2CL: t2_lat[7:0] = c.wd;
        via_pkg::RS_T2CH: begin t2_lat[15:8] = c.wd; t2c = 1'b1; t2_go = 1'b1; end
        via_pkg::RS_SR: begin sreg = c.wd; src = 1'b1; sr_go = 1'b1; end
        via_pkg::RS_ACR: begin acr = c.wd; if (cb1_out_mode(acr[4:2])) lvl_cb1 = 1'b1; end
        via_pkg::RS_PCR: pcr = c.wd;
        via_pkg::RS_IFR: ifr = ifr & ~{1'b0, c.wd[6:0]};
        default: ier = c.wd[7] ? (ier | c.wd[6:0]) : (ier & ~c.wd[6:0]);
      endcase
    end else if (c.sel) begin
      case (c.addr)
        via_pkg::RS_ORB: begin rd_b = 1'b1; rdata = (lat_b & ~ddrb) | (orb & ddrb); end
        via_pkg::RS_ORA: begin rd_a = 1'b1; rdata = lat_a; end
        via_pkg::RS_DDRB: rdata = ddrb;
        via_pkg::RS_DDRA: rdata = ddra;
        via_pkg::RS_T1CL: begin t1c = 1'b1; rdata = t1_cnt[7:0]; end
        via_pkg::RS_T1CH: rdata = t1_cnt[15:8];
        via_pkg::RS_T1LL: rdata = t1_lat[7:0];
        via_pkg::RS_T1LH: rdata = t1_lat[15:8];
        via_pkg::RS_T2CL: begin t2c = 1'b1; rdata = t2_cnt[7:0]; end
        via_pkg::RS_T2CH: rdata = t2_cnt[15:8];
        via_pkg::RS_SR: begin src = 1'b1; sr_go = 1'b1; rdata = sreg; end
        via_pkg::RS_ACR: rdata = acr;
        via_pkg::RS_PCR: rdata = pcr;
        via_pkg::RS_IFR: rdata = ifr;
        via_pkg::RS_IER: rdata = {1'b1, ier};
        default: rdata = c.pa;
      endcase
      if (rd_a) hold_a = 1'b0;
      if (rd_b) hold_b = 1'b0;
    end

    // the new PCR/ACR already governs this cycle
    if (pcr[3]) lvl_ca2 = ctl2_level(pcr[3:0], lvl_ca2, rd_a || wr_a, ca1t);
    if (pcr[7] && !acr[4]) lvl_cb2 = ctl2_level(pcr[7:4], lvl_cb2, wr_b, cb1t);

    setf = {1'b0, t1s, t2s, cb1t, cb2t, srs, ca1t, ca2t};
    clr = '0;
    if (rd_a || wr_a) clr |= 8'h03;
    if (src) clr |= 8'h04;
    if (rd_b || wr_b) clr |= 8'h18;
    if (t2c) clr |= 8'h20;
    if (t1c) clr |= 8'h40;
    if ((pcr & 8'h0A) == 8'h02) clr[0] = 1'b0;
    if ((pcr & 8'hA0) == 8'h20) clr[3] = 1'b0;
    ifr = (ifr | setf) & ~clr;
    ifr[7] = |(ifr[6:0] & ier);

    r.read_data = rdata;
    r.read_valid = c.sel && c.rd;
    r.irq_n = !ifr[7];
    r.port_a_out = ora;
    r.port_a_dir = ddra;
    r.port_b_out = orb;
    r.port_b_dir = ddrb;
    r.ctrl_drive = {pcr[7] || acr[4], cb1_out_mode(acr[4:2]), pcr[3]};
    r.ctrl_level = r.ctrl_drive & {lvl_cb2, lvl_cb1, lvl_ca2};
  endtask

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      failures++;
    end
  endfunction

  // accept and predict on the input side, check results on the output side
  always @(posedge clk) begin
    via_pkg::via_res_t p, e;
    cycles++;
    if (rst_n) begin
      taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        adapter_cycle(cur, p);
        expected_res.push_back(p);
      end
      if (out_valid && !out_stall) begin
        if (expected_res.size() == 0) begin
          $error("result with no request outstanding");
          failures++;
        end else begin
          e = expected_res.pop_front();
          n_checked++;
          if (!e.irq_n) n_irq++;
          if (e.read_valid) n_reads++;
          check_field("read_data", e.read_data, out_read_data);
          check_field("read_valid", e.read_valid, out_read_valid);
          check_field("irq_n", e.irq_n, out_irq_n);
          check_field("port_a_out", e.port_a_out, out_port_a_out);
          check_field("port_a_dir", e.port_a_dir, out_port_a_dir);
          check_field("port_b_out", e.port_b_out, out_port_b_out);
          check_field("port_b_dir", e.port_b_dir, out_port_b_dir);
          check_field("ctrl_drive", e.ctrl_drive, out_ctrl_drive);
          check_field("ctrl_level", e.ctrl_level, out_ctrl_level);
        end
      end
    end
    if (cycles > 200000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // request driver and output stall generator
  always @(negedge clk) begin
    logic nv;
    if (rst_n) begin
      nv = in_valid;
      if (!in_valid || taken) begin
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending.size() > 0 && idling && $urandom_range(0, 15) == 0) begin
          in_gap = int'($urandom_range(0, 14));
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          in_select <= cur.sel;
          in_func <= cur.rd;
          in_reg_addr <= cur.addr;
          in_write_data <= cur.wd;
          in_port_a_pins <= cur.pa;
          in_port_b_pins <= cur.pb;
          in_ca1_pin <= cur.ca1;
          in_ca2_pin <= cur.ca2;
          in_cb1_pin <= cur.cb1;
          in_cb2_pin <= cur.cb2;
          nv = 1'b1;
        end
      end
      in_valid <= nv;
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 15) == 0) begin
        out_gap = int'($urandom_range(0, 14));
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_cycle(logic sel, logic rd, via_pkg::via_reg_t addr, logic [7:0] wd);
    bus_cycle_t c;
    c.sel = sel;
    c.rd = rd;
    c.addr = addr;
    c.wd = wd;
    c.pa = 8'($urandom);
    c.pb = 8'($urandom);
    {c.ca1, c.ca2, c.cb1, c.cb2} = 4'($urandom);
    pending.push_back(c);
  endtask

  // timer-friendly data: high bytes mostly zero so timers expire often
  function automatic logic [7:0] pick_data(via_pkg::via_reg_t a);
    if ((a == via_pkg::RS_T1CH || a == via_pkg::RS_T1LH || a == via_pkg::RS_T2CH) &&
        $urandom_range(0, 9) < 8)
      return 8'd0;
    if ((a == via_pkg::RS_T1CL || a == via_pkg::RS_T1LL || a == via_pkg::RS_T2CL) &&
        $urandom_range(0, 3) != 0)
      return 8'($urandom_range(0, 12));
    return 8'($urandom);
  endfunction

  initial begin
    via_pkg::via_reg_t a;
    int k;
    adapter_reset();
    // directed: most registers written, every register read, extremes, edges, timers
    add_cycle(1'b1, 1'b0, via_pkg::RS_DDRA, 8'hFF);
    add_cycle(1'b1, 1'b0, via_pkg::RS_DDRB, 8'hFF);
    add_cycle(1'b1, 1'b0, via_pkg::RS_ORA, 8'hFF);
    add_cycle(1'b1, 1'b0, via_pkg::RS_ORB, 8'h00);
    add_cycle(1'b1, 1'b0, via_pkg::RS_IER, 8'hFF);
    add_cycle(1'b1, 1'b0, via_pkg::RS_PCR, 8'hAA);
    add_cycle(1'b1, 1'b0, via_pkg::RS_ACR, 8'hDF);
    add_cycle(1'b1, 1'b0, via_pkg::RS_T1LL, 8'h02);
    add_cycle(1'b1, 1'b0, via_pkg::RS_T1CH, 8'h00);
    add_cycle(1'b1, 1'b0, via_pkg::RS_T2CL, 8'h01);
    add_cycle(1'b1, 1'b0, via_pkg::RS_T2CH, 8'h00);
    add_cycle(1'b1, 1'b0, via_pkg::RS_SR, 8'hA5);
    add_cycle(1'b0, 1'b1, via_pkg::RS_IFR, 8'h00);
    for (int i = 0; i < 16; i++) add_cycle(1'b1, 1'b1, via_pkg::via_reg_t'(i), 8'h00);
    add_cycle(1'b1, 1'b0, via_pkg::RS_IFR, 8'hFF);
    add_cycle(1'b1, 1'b0, via_pkg::RS_IER, 8'h7F);
    add_cycle(1'b1, 1'b0, via_pkg::RS_ORA_NH, 8'h00);
    add_cycle(1'b1, 1'b0, via_pkg::RS_T1LH, 8'hFF);
    add_cycle(1'b1, 1'b0, via_pkg::RS_ACR, 8'h00);
    add_cycle(1'b1, 1'b0, via_pkg::RS_PCR, 8'h00);

    // random: mostly configure-then-run sequences, some pure noise
    k = 0;
    while (k < 1450) begin
      if ($urandom_range(0, 3) != 0) begin
        add_cycle(1'b1, 1'b0, via_pkg::RS_ACR, 8'($urandom));
        add_cycle(1'b1, 1'b0, via_pkg::RS_PCR, 8'($urandom));
        add_cycle(1'b1, 1'b0, via_pkg::RS_IER, 8'($urandom));
        a = ($urandom_range(0, 2) == 0) ? via_pkg::RS_T2CH :
            (($urandom_range(0, 1) != 0) ? via_pkg::RS_T1CH : via_pkg::RS_SR);
        add_cycle(1'b1, 1'b0, a, pick_data(a));
        k += 4;
        for (int j = int'($urandom_range(4, 20)); j > 0; j--) begin
          a = via_pkg::via_reg_t'($urandom_range(0, 15));
          add_cycle($urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)), a, pick_data(a));
          k++;
        end
      end else begin
        a = via_pkg::via_reg_t'($urandom_range(0, 15));
        add_cycle(1'($urandom), 1'($urandom), a, pick_data(a));
        k++;
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (pending.size() < 150);
    idling = 1'b0;
    wait (pending.size() == 0 && !in_valid && expected_res.size() == 0);
    repeat (5) @(posedge clk);
    $display("Checked %0d bus cycles: %0d reads, %0d with irq asserted.",
             n_checked, n_reads, n_irq);
    if (failures == 0 && expected_res.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
